FILE: src/rrc_pkg.sv
// ----------------------------------------------------------------------------
// rrc_pkg
// Shared types and constants of the range request coalescer.
// ----------------------------------------------------------------------------
package rrc_pkg;

    localparam int MAX_BATCH_DEF = 32;
    localparam int QUEUE_DEPTH   = 2;
    localparam int MUL_STEPS     = 64;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MERGE_GAP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PARTS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPAN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AMP   = 2'd3;

    localparam logic [63:0] MERGE_GAP_RST = 64'd0;
    localparam logic [6:0]  MAX_PARTS_RST = 7'd16;
    localparam logic [63:0] MAX_SPAN_RST  = 64'd1048576;
    localparam logic [63:0] MAX_AMP_RST   = 64'd4;

    localparam logic [1:0] ST_PLANNED     = 2'd0;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
    localparam logic [1:0] ST_RANGE       = 2'd2;

    // classified request passed from front to back
    typedef struct packed {
        logic [15:0] resource_id;
        logic [31:0] req_tag;
        logic [63:0] abs_start;
        logic [63:0] req_length;
        logic [1:0]  status;
        logic        batch_end;
    } item_t;

    // one held request in the batch store
    typedef struct packed {
        logic [15:0] resource;
        logic [63:0] start;
        logic [63:0] length;
        logic [31:0] tag;
    } held_t;

    typedef struct packed {
        logic [31:0] out_tag;
        logic [1:0]  out_status;
        logic        starts_transfer;
        logic [63:0] transfer_start;
        logic [63:0] transfer_length;
        logic [63:0] part_offset;
        logic [63:0] part_length;
        logic        scattered;
        logic        last_result;
    } res_t;

endpackage

FILE: src/rrc_if.sv
// ----------------------------------------------------------------------------
// rrc_if
// Channel interfaces: request input, result output and register writes.
// ----------------------------------------------------------------------------
interface rrc_req_if;
    import rrc_pkg::*;
    logic        valid;
    logic        ready;
    logic [15:0] resource_id;
    logic        is_local_file;
    logic        has_precondition;
    logic [63:0] req_offset;
    logic [63:0] req_length;
    logic [63:0] window_start;
    logic [63:0] window_size;
    logic        window_open;
    logic [31:0] req_tag;
    logic        batch_end;

    modport source (output valid, resource_id, is_local_file, has_precondition, req_offset,
                    req_length, window_start, window_size, window_open, req_tag, batch_end,
                    input ready);
    modport sink (input valid, resource_id, is_local_file, has_precondition, req_offset,
                  req_length, window_start, window_size, window_open, req_tag, batch_end,
                  output ready);
endinterface

interface rrc_rsp_if;
    import rrc_pkg::*;
    logic        valid;
    logic        ready;
    logic [31:0] out_tag;
    logic [1:0]  out_status;
    logic        starts_transfer;
    logic [63:0] transfer_start;
    logic [63:0] transfer_length;
    logic [63:0] part_offset;
    logic [63:0] part_length;
    logic        scattered;
    logic        last_result;

    modport source (output valid, out_tag, out_status, starts_transfer, transfer_start,
                    transfer_length, part_offset, part_length, scattered, last_result,
                    input ready);
    modport sink (input valid, out_tag, out_status, starts_transfer, transfer_start,
                  transfer_length, part_offset, part_length, scattered, last_result,
                  output ready);
endinterface

interface rrc_cfg_if;
    import rrc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [63:0]          data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: src/range_request_coalescer.sv
// ----------------------------------------------------------------------------
// range_request_coalescer
// Top level: request checker, classified queue and batch planner.
// ----------------------------------------------------------------------------
// The checker takes a new request only after it has pushed the last one into
// the queue. The planner stores a valid request in the batch store and sends
// an error result through its error state. The request that closes a batch of
// n held requests starts the planner. A selection sort over the batch store
// then runs, with one store read per compare. In the merge walk that comes
// next, a shift-add multiplier checks the amplification bound on each merge
// attempt. Results leave through an output register. A result that is not
// taken holds the planner, and once the short queue is full the checker
// stops taking requests. No clearing pass is needed after reset.
module range_request_coalescer #(
    parameter int MAX_BATCH = rrc_pkg::MAX_BATCH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    rrc_req_if.sink    req,
    rrc_rsp_if.source  rsp,
    rrc_cfg_if.sink    cfg
);
    import rrc_pkg::*;

    logic  f_valid, f_ready, b_valid, b_ready;
    item_t f_item, b_item;

    rrc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_valid (f_valid),
        .q_ready (f_ready),
        .q_item  (f_item)
    );

    rrc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_item  (b_item)
    );

    rrc_back #(.MAX_BATCH(MAX_BATCH)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (b_valid),
        .q_ready (b_ready),
        .q_item  (b_item),
        .rsp     (rsp),
        .cfg     (cfg)
    );
endmodule

FILE: src/rrc_ram.sv
// ----------------------------------------------------------------------------
// rrc_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module rrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

FILE: src/rrc_front.sv
// ----------------------------------------------------------------------------
// rrc_front
// Accepts requests, checks precondition and range, forms the absolute start.
// ----------------------------------------------------------------------------
module rrc_front (
    input  logic           clk,
    input  logic           rst_n,
    rrc_req_if.sink        req,
    output logic           q_valid,
    input  logic           q_ready,
    output rrc_pkg::item_t q_item
);
    import rrc_pkg::*;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_CHK  = 3'b010,
        F_PUSH = 3'b100
    } fstate_t;

    fstate_t     state_reg, state_next;
    logic [15:0] res_reg;
    logic        local_reg, pre_reg, open_reg, end_reg;
    logic [63:0] off_reg, len_reg, ws_reg, wsz_reg;
    logic [31:0] tag_reg;
    logic        off_gt_reg;
    logic [63:0] rem_reg;
    logic [64:0] sum_reg;
    logic [1:0]  status;

    assign req.ready = (state_reg == F_IDLE);
    assign q_valid   = (state_reg == F_PUSH);

    always_comb
    begin
        if (local_reg && pre_reg)
        begin
            status = ST_UNSUPPORTED;
        end
        else if (!open_reg && (off_gt_reg || (len_reg > rem_reg)))
        begin
            status = ST_RANGE;
        end
        else if (sum_reg[64])
        begin
            status = ST_RANGE;
        end
        else if ((len_reg - 64'd1) > ~sum_reg[63:0])
        begin
            status = ST_RANGE;
        end
        else
        begin
            status = ST_PLANNED;
        end
    end

    always_comb
    begin
        q_item.resource_id = res_reg;
        q_item.req_tag     = tag_reg;
        q_item.abs_start   = sum_reg[63:0];
        q_item.req_length  = len_reg;
        q_item.status      = status;
        q_item.batch_end   = end_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = F_CHK;
                end
            end
            F_CHK:
            begin
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (q_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && req.valid)
        begin
            res_reg   <= req.resource_id;
            local_reg <= req.is_local_file;
            pre_reg   <= req.has_precondition;
            off_reg   <= req.req_offset;
            len_reg   <= req.req_length;
            ws_reg    <= req.window_start;
            wsz_reg   <= req.window_size;
            open_reg  <= req.window_open;
            tag_reg   <= req.req_tag;
            end_reg   <= req.batch_end;
        end
        if (state_reg == F_CHK)
        begin
            off_gt_reg <= off_reg > wsz_reg;
            rem_reg    <= wsz_reg - off_reg;
            sum_reg    <= {1'b0, ws_reg} + {1'b0, off_reg};
        end
    end
endmodule

FILE: src/rrc_queue.sv
// ----------------------------------------------------------------------------
// rrc_queue
// Short queue of classified requests between the front and the back.
// ----------------------------------------------------------------------------
module rrc_queue #(
    parameter int DEPTH = rrc_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  rrc_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output rrc_pkg::item_t out_item
);
    import rrc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end
endmodule

FILE: src/rrc_back.sv
// ----------------------------------------------------------------------------
// rrc_back
// Holds the batch, sorts it by resource and start, merges and emits parts.
// ----------------------------------------------------------------------------
module rrc_back #(
    parameter int MAX_BATCH = rrc_pkg::MAX_BATCH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    output logic           q_ready,
    input  rrc_pkg::item_t q_item,
    rrc_rsp_if.source      rsp,
    rrc_cfg_if.sink        cfg
);
    import rrc_pkg::*;

    localparam int IDX_W  = $clog2(MAX_BATCH);
    localparam int CNT_W  = $clog2(MAX_BATCH + 1);
    localparam int KEY_W  = 16 + 64 + IDX_W;
    localparam int HELD_W = $bits(held_t);
    localparam int MCNT_W = $clog2(MUL_STEPS);

    typedef enum logic [21:0] {
        B_IDLE = 22'h000001,
        B_ERR  = 22'h000002,
        S_RD   = 22'h000004,
        S_CMP  = 22'h000008,
        S_PUT  = 22'h000010,
        W_HORD = 22'h000020,
        W_HDAT = 22'h000040,
        W_HGOT = 22'h000080,
        W_TRY  = 22'h000100,
        W_CORD = 22'h000200,
        W_CDAT = 22'h000400,
        W_C1   = 22'h000800,
        W_C2   = 22'h001000,
        W_C3   = 22'h002000,
        W_C4   = 22'h004000,
        W_MUL  = 22'h008000,
        W_C5   = 22'h010000,
        W_ESET = 22'h020000,
        W_ESCT = 22'h040000,
        W_EORD = 22'h080000,
        W_EDAT = 22'h100000,
        W_EOUT = 22'h200000
    } bstate_t;

    bstate_t          state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    res_t             out_reg, out_next;
    logic [63:0]      gap_reg, gap_next, span_reg, span_next, amp_reg, amp_next;
    logic [6:0]       parts_max_reg, parts_max_next;
    logic             have_prev_reg, have_prev_next, have_best_reg, have_best_next;
    logic             close_reg, close_next;

    logic [CNT_W-1:0] scan_reg, scan_next, k_reg, k_next, pos_reg, pos_next;
    logic [CNT_W-1:0] first_reg, first_next, nxt_reg, nxt_next, ep_reg, ep_next;
    logic [KEY_W-1:0] prev_reg, prev_next, best_reg, best_next;
    logic [63:0]      start_reg, start_next, hlen_reg, hlen_next;
    logic [15:0]      hres_reg, hres_next;
    logic [63:0]      last_reg, last_next, useful_reg, useful_next;
    logic [6:0]       parts_reg, parts_next;
    logic [63:0]      clen_reg, clen_next, cl_reg, cl_next;
    logic             gt_reg, gt_next;
    logic [63:0]      diff_reg, diff_next, ml_reg, ml_next, mlen_reg, mlen_next;
    logic [63:0]      mu_reg, mu_next, mul_a_reg, mul_a_next;
    logic [63:0]      mul_hi_reg, mul_hi_next, mul_lo_reg, mul_lo_next;
    logic [MCNT_W-1:0] mcnt_reg, mcnt_next;
    logic [63:0]      tlen_reg, tlen_next;
    logic             scat_reg, scat_next;
    logic [31:0]      etag_reg, etag_next;
    logic [1:0]       estat_reg, estat_next;

    logic              data_we, data_re, ord_we, ord_re;
    logic [IDX_W-1:0]  data_raddr;
    logic [HELD_W-1:0] data_rdata;
    logic [IDX_W-1:0]  ord_rdata;
    held_t             wr_held, rd;
    logic [KEY_W-1:0]  key_i;
    logic              out_free, out_load, close_in;
    logic [6:0]        limit;
    logic [64:0]       usum, msum;
    logic [63:0]       dml;

    rrc_ram #(.WIDTH(HELD_W), .DEPTH(MAX_BATCH)) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (cnt_reg[IDX_W-1:0]),
        .wdata (wr_held),
        .re    (data_re),
        .raddr (data_raddr),
        .rdata (data_rdata)
    );

    rrc_ram #(.WIDTH(IDX_W), .DEPTH(MAX_BATCH)) u_order_ram (
        .clk   (clk),
        .we    (ord_we),
        .waddr (k_reg[IDX_W-1:0]),
        .wdata (best_reg[IDX_W-1:0]),
        .re    (ord_re),
        .raddr (pos_reg[IDX_W-1:0]),
        .rdata (ord_rdata)
    );

    assign rd        = held_t'(data_rdata);
    assign key_i     = {rd.resource, rd.start, scan_reg[IDX_W-1:0]};
    assign out_free  = !out_valid_reg || rsp.ready;
    assign limit     = (parts_max_reg == '0) ? 7'd1 : parts_max_reg;
    assign q_ready   = (state_reg == B_IDLE);
    assign close_in  = q_item.batch_end || (cnt_reg >= CNT_W'(MAX_BATCH - 1));
    assign cfg.ready = 1'b1;

    assign wr_held.resource = q_item.resource_id;
    assign wr_held.start    = q_item.abs_start;
    assign wr_held.length   = q_item.req_length;
    assign wr_held.tag      = q_item.req_tag;

    assign data_we    = (state_reg == B_IDLE) && q_valid && (q_item.status == ST_PLANNED);
    assign data_re    = (state_reg == S_RD) || (state_reg == W_HDAT) ||
                        (state_reg == W_CDAT) || (state_reg == W_EDAT);
    assign data_raddr = (state_reg == S_RD) ? scan_reg[IDX_W-1:0] : ord_rdata;
    assign ord_we     = (state_reg == S_PUT);
    assign ord_re     = (state_reg == W_HORD) || (state_reg == W_CORD) ||
                        (state_reg == W_EORD);

    assign usum = {1'b0, useful_reg} + {1'b0, clen_reg};
    assign dml  = ml_reg - start_reg;
    assign msum = {1'b0, mul_hi_reg} + {1'b0, mul_a_reg};

    assign rsp.valid           = out_valid_reg;
    assign rsp.out_tag         = out_reg.out_tag;
    assign rsp.out_status      = out_reg.out_status;
    assign rsp.starts_transfer = out_reg.starts_transfer;
    assign rsp.transfer_start  = out_reg.transfer_start;
    assign rsp.transfer_length = out_reg.transfer_length;
    assign rsp.part_offset     = out_reg.part_offset;
    assign rsp.part_length     = out_reg.part_length;
    assign rsp.scattered       = out_reg.scattered;
    assign rsp.last_result     = out_reg.last_result;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_next       = out_reg;
        out_load       = 1'b0;
        gap_next       = gap_reg;
        span_next      = span_reg;
        amp_next       = amp_reg;
        parts_max_next = parts_max_reg;
        have_prev_next = have_prev_reg;
        have_best_next = have_best_reg;
        close_next     = close_reg;
        scan_next      = scan_reg;
        k_next         = k_reg;
        pos_next       = pos_reg;
        first_next     = first_reg;
        nxt_next       = nxt_reg;
        ep_next        = ep_reg;
        prev_next      = prev_reg;
        best_next      = best_reg;
        start_next     = start_reg;
        hlen_next      = hlen_reg;
        hres_next      = hres_reg;
        last_next      = last_reg;
        useful_next    = useful_reg;
        parts_next     = parts_reg;
        clen_next      = clen_reg;
        cl_next        = cl_reg;
        gt_next        = gt_reg;
        diff_next      = diff_reg;
        ml_next        = ml_reg;
        mlen_next      = mlen_reg;
        mu_next        = mu_reg;
        mul_a_next     = mul_a_reg;
        mul_hi_next    = mul_hi_reg;
        mul_lo_next    = mul_lo_reg;
        mcnt_next      = mcnt_reg;
        tlen_next      = tlen_reg;
        scat_next      = scat_reg;
        etag_next      = etag_reg;
        estat_next     = estat_reg;

        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_MERGE_GAP: gap_next       = cfg.data;
                CFG_MAX_PARTS: parts_max_next = cfg.data[6:0];
                CFG_MAX_SPAN:  span_next      = cfg.data;
                CFG_MAX_AMP:   amp_next       = cfg.data;
                default:       gap_next       = gap_reg;
            endcase
        end

        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    close_next = close_in;
                    if (q_item.status != ST_PLANNED)
                    begin
                        etag_next  = q_item.req_tag;
                        estat_next = q_item.status;
                        state_next = B_ERR;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                        if (close_in)
                        begin
                            k_next         = '0;
                            scan_next      = '0;
                            have_prev_next = 1'b0;
                            have_best_next = 1'b0;
                            state_next     = S_RD;
                        end
                    end
                end
            end
            B_ERR:
            begin
                if (out_free)
                begin
                    out_load                 = 1'b1;
                    out_next                 = '0;
                    out_next.out_tag         = etag_reg;
                    out_next.out_status      = estat_reg;
                    out_next.last_result     = close_reg && (cnt_reg == '0);
                    if (close_reg && (cnt_reg != '0))
                    begin
                        k_next         = '0;
                        scan_next      = '0;
                        have_prev_next = 1'b0;
                        have_best_next = 1'b0;
                        state_next     = S_RD;
                    end
                    else
                    begin
                        state_next = B_IDLE;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                // pick the smallest key above the one placed last
                if ((!have_prev_reg || (key_i > prev_reg)) &&
                    (!have_best_reg || (key_i < best_reg)))
                begin
                    best_next      = key_i;
                    have_best_next = 1'b1;
                end
                scan_next  = scan_reg + 1'b1;
                state_next = (scan_reg + 1'b1 == cnt_reg) ? S_PUT : S_RD;
            end
            S_PUT:
            begin
                prev_next      = best_reg;
                have_prev_next = 1'b1;
                k_next         = k_reg + 1'b1;
                if (k_reg + 1'b1 == cnt_reg)
                begin
                    first_next = '0;
                    pos_next   = '0;
                    state_next = W_HORD;
                end
                else
                begin
                    scan_next      = '0;
                    have_best_next = 1'b0;
                    state_next     = S_RD;
                end
            end
            W_HORD:
            begin
                state_next = W_HDAT;
            end
            W_HDAT:
            begin
                state_next = W_HGOT;
            end
            W_HGOT:
            begin
                start_next  = rd.start;
                hlen_next   = rd.length;
                hres_next   = rd.resource;
                last_next   = rd.start + rd.length - 64'd1;
                useful_next = rd.length;
                parts_next  = 7'd1;
                nxt_next    = first_reg + 1'b1;
                state_next  = W_TRY;
            end
            W_TRY:
            begin
                if ((gap_reg == '0) || (nxt_reg >= cnt_reg))
                begin
                    state_next = W_ESET;
                end
                else
                begin
                    pos_next   = nxt_reg;
                    state_next = W_CORD;
                end
            end
            W_CORD:
            begin
                state_next = W_CDAT;
            end
            W_CDAT:
            begin
                state_next = W_C1;
            end
            W_C1:
            begin
                if (rd.resource != hres_reg)
                begin
                    state_next = W_ESET;
                end
                else
                begin
                    clen_next  = rd.length;
                    cl_next    = rd.start + rd.length - 64'd1;
                    gt_next    = rd.start > last_reg;
                    diff_next  = rd.start - last_reg;
                    state_next = W_C2;
                end
            end
            W_C2:
            begin
                if (gt_reg && ((diff_reg - 64'd1) > gap_reg))
                begin
                    state_next = W_ESET;
                end
                else
                begin
                    ml_next    = (cl_reg > last_reg) ? cl_reg : last_reg;
                    state_next = W_C3;
                end
            end
            W_C3:
            begin
                if (&dml)
                begin
                    state_next = W_ESET;
                end
                else
                begin
                    mlen_next  = dml + 64'd1;
                    mu_next    = usum[64] ? '1 : usum[63:0];
                    state_next = W_C4;
                end
            end
            W_C4:
            begin
                if ((parts_reg >= limit) || (mlen_reg > span_reg))
                begin
                    state_next = W_ESET;
                end
                else
                begin
                    mul_a_next  = mu_reg;
                    mul_hi_next = '0;
                    mul_lo_next = amp_reg;
                    mcnt_next   = '0;
                    state_next  = W_MUL;
                end
            end
            W_MUL:
            begin
                // shift-add: one multiplier bit per cycle
                if (mul_lo_reg[0])
                begin
                    mul_hi_next = msum[64:1];
                    mul_lo_next = {msum[0], mul_lo_reg[63:1]};
                end
                else
                begin
                    mul_hi_next = {1'b0, mul_hi_reg[63:1]};
                    mul_lo_next = {mul_hi_reg[0], mul_lo_reg[63:1]};
                end
                mcnt_next = mcnt_reg + 1'b1;
                if (mcnt_reg == MCNT_W'(MUL_STEPS - 1))
                begin
                    state_next = W_C5;
                end
            end
            W_C5:
            begin
                if ((mul_hi_reg == '0) && (mul_lo_reg < mlen_reg))
                begin
                    state_next = W_ESET;
                end
                else
                begin
                    last_next   = ml_reg;
                    useful_next = mu_reg;
                    parts_next  = parts_reg + 1'b1;
                    nxt_next    = nxt_reg + 1'b1;
                    state_next  = W_TRY;
                end
            end
            W_ESET:
            begin
                tlen_next  = last_reg - start_reg + 64'd1;
                state_next = W_ESCT;
            end
            W_ESCT:
            begin
                scat_next  = (parts_reg != 7'd1) || (hlen_reg != tlen_reg);
                ep_next    = first_reg;
                pos_next   = first_reg;
                state_next = W_EORD;
            end
            W_EORD:
            begin
                state_next = W_EDAT;
            end
            W_EDAT:
            begin
                state_next = W_EOUT;
            end
            W_EOUT:
            begin
                if (out_free)
                begin
                    out_load                 = 1'b1;
                    out_next.out_tag         = rd.tag;
                    out_next.out_status      = ST_PLANNED;
                    out_next.starts_transfer = (ep_reg == first_reg);
                    out_next.transfer_start  = start_reg;
                    out_next.transfer_length = tlen_reg;
                    out_next.part_offset     = rd.start - start_reg;
                    out_next.part_length     = rd.length;
                    out_next.scattered       = scat_reg;
                    out_next.last_result     = (ep_reg + 1'b1 == nxt_reg) &&
                                               (nxt_reg == cnt_reg);
                    ep_next = ep_reg + 1'b1;
                    if (ep_reg + 1'b1 == nxt_reg)
                    begin
                        if (nxt_reg >= cnt_reg)
                        begin
                            cnt_next   = '0;
                            state_next = B_IDLE;
                        end
                        else
                        begin
                            first_next = nxt_reg;
                            pos_next   = nxt_reg;
                            state_next = W_HORD;
                        end
                    end
                    else
                    begin
                        pos_next   = ep_reg + 1'b1;
                        state_next = W_EORD;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            gap_reg       <= MERGE_GAP_RST;
            parts_max_reg <= MAX_PARTS_RST;
            span_reg      <= MAX_SPAN_RST;
            amp_reg       <= MAX_AMP_RST;
            have_prev_reg <= 1'b0;
            have_best_reg <= 1'b0;
            close_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            gap_reg       <= gap_next;
            parts_max_reg <= parts_max_next;
            span_reg      <= span_next;
            amp_reg       <= amp_next;
            have_prev_reg <= have_prev_next;
            have_best_reg <= have_best_next;
            close_reg     <= close_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg    <= out_next;
        scan_reg   <= scan_next;
        k_reg      <= k_next;
        pos_reg    <= pos_next;
        first_reg  <= first_next;
        nxt_reg    <= nxt_next;
        ep_reg     <= ep_next;
        prev_reg   <= prev_next;
        best_reg   <= best_next;
        start_reg  <= start_next;
        hlen_reg   <= hlen_next;
        hres_reg   <= hres_next;
        last_reg   <= last_next;
        useful_reg <= useful_next;
        parts_reg  <= parts_next;
        clen_reg   <= clen_next;
        cl_reg     <= cl_next;
        gt_reg     <= gt_next;
        diff_reg   <= diff_next;
        ml_reg     <= ml_next;
        mlen_reg   <= mlen_next;
        mu_reg     <= mu_next;
        mul_a_reg  <= mul_a_next;
        mul_hi_reg <= mul_hi_next;
        mul_lo_reg <= mul_lo_next;
        mcnt_reg   <= mcnt_next;
        tlen_reg   <= tlen_next;
        scat_reg   <= scat_next;
        etag_reg   <= etag_next;
        estat_reg  <= estat_next;
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_BATCH))
        else $error("held count beyond batch size");

    a_sort_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD || state_reg == S_CMP || state_reg == S_PUT) |-> !out_load)
        else $error("result loaded during sort");

    a_emit_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == W_EOUT) |-> (ep_reg < nxt_reg) && (nxt_reg <= cnt_reg))
        else $error("emitted part outside its transfer");

    a_parts_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == W_TRY) |-> (parts_reg <= limit))
        else $error("transfer holds more parts than allowed");
`endif
endmodule
